// ----- src/pxhist_pkg.sv -----
// Shared types and constants of the pixel histogram with mode unit.
package pxhist_pkg;

    localparam int COUNT_W    = 25;
    localparam int BIN_W      = 16;
    localparam int CFG_SIDE_W = 13;
    localparam int EPOCH_W    = 8;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 72;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

    localparam logic REQ_PIXEL    = 1'b0;
    localparam logic REQ_READ     = 1'b1;
    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_READ    = 1'b1;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_COUNT_EN     = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic               kind;
        logic [COUNT_W-1:0] mode_count;
        logic [BIN_W-1:0]   mode_bin;
        logic [COUNT_W-1:0] bin_count;
    } t_result;

endpackage

// ----- src/pxhist_ram.sv -----
// Generic single-write, single-read RAM with registered read (read-before-write).
module pxhist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- src/pixel_histogram_with_mode_unit.sv -----
// Top level of the pixel histogram with running mode.
//
//  Channel  | Direction | Handshake               | Content
//  ---------+-----------+-------------------------+-------------------------------------
//  APB      | in/out    | psel, penable, pready   | frame_width, frame_height, count enable
//  s_axis   | in        | s_axis_tvalid/tready    | pixel or bin-read request
//  m_axis   | out       | m_axis_tvalid/tready    | frame summary or bin-read answer
//
// One transaction per clock in steady state. A request is read from the bin memory
// on acceptance and resolved in the next cycle (read-modify-write, with forwarding of
// the previous write), its result landing in a three-entry output queue.
// Reset is synchronous; after reset a sweep walks every entry of the bin
// memory with s_axis_tready low. The same sweep follows every (2^EPOCH_W - 1)th frame,
// with tready also low in the cycle that resolves that frame's last pixel.
// s_axis_tready also drops while the output queue cannot take another result.
module pixel_histogram_with_mode_unit
    import pxhist_pkg::*;
#(
    parameter int PIXEL_BITS = 16,
    parameter int MAX_SIDE   = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    // requests
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // pixel_value[15:0], read_bin[31:16]
    input  logic [0:0]            s_axis_tuser,   // req_type[0]
    // results
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // mode_count[24:0], mode_bin[40:25],
                                                  // bin_count[65:41], zero[71:66]
    output logic [0:0]            m_axis_tuser    // result_kind[0]
);

    localparam int DEPTH      = 1 << PIXEL_BITS;
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int TOT_W      = 2 * SIDE_W;
    localparam int MEM_W      = EPOCH_W + COUNT_W;
    localparam int FIFO_DEPTH = 3;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_SIDE_W-1:0] r_frame_width;
    logic [CFG_SIDE_W-1:0] r_frame_height;
    logic                  r_count_en;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_SIDE_W'(1024);
            r_frame_height <= CFG_SIDE_W'(1024);
            r_count_en     <= 1'b1;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[CFG_SIDE_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[CFG_SIDE_W-1:0];
                REG_COUNT_EN:     r_count_en     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_FRAME_WIDTH:  prdata = 32'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = 32'(r_frame_height);
            REG_COUNT_EN:     prdata = 32'(r_count_en);
            default:          prdata = '0;
        endcase
    end

    // Frame size: each side clamped to 1..MAX_SIDE, product kept in a register.
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_SIDE_W-1:0] v);
        if (v == '0) begin
            return SIDE_W'(1);
        end else if (int'(v) > MAX_SIDE) begin
            return SIDE_W'(MAX_SIDE);
        end
        return SIDE_W'(v);
    endfunction

    logic [TOT_W-1:0] r_total;

    always_ff @(posedge i_clk) begin
        r_total <= TOT_W'(clamp_side(r_frame_width)) * TOT_W'(clamp_side(r_frame_height));
    end

    // ------------------------------------------------------------------
    // Bin memory: {epoch tag, count}. An entry counts only if its tag
    // matches the current epoch, so a frame start clears every bin at once.
    // ------------------------------------------------------------------
    logic                  mem_we;
    logic [PIXEL_BITS-1:0] mem_waddr;
    logic [MEM_W-1:0]      mem_wdata;
    logic [PIXEL_BITS-1:0] mem_raddr;
    logic [MEM_W-1:0]      mem_rdata;
    logic [EPOCH_W-1:0]    rd_tag;
    logic [COUNT_W-1:0]    rd_cnt;

    pxhist_ram #(
        .WIDTH (MEM_W),
        .DEPTH (DEPTH)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_tag = mem_rdata[MEM_W-1:COUNT_W];
    assign rd_cnt = mem_rdata[COUNT_W-1:0];

    // ------------------------------------------------------------------
    // Request intake
    // ------------------------------------------------------------------
    logic                  in_acc;
    logic                  in_type;
    logic [BIN_W-1:0]      in_pixel;
    logic [BIN_W-1:0]      in_rbin;
    logic [PIXEL_BITS-1:0] in_addr;
    logic                  in_oob;

    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign in_type  = s_axis_tuser[0];
    assign in_pixel = s_axis_tdata[BIN_W-1:0];
    assign in_rbin  = s_axis_tdata[2*BIN_W-1:BIN_W];
    assign in_addr  = (in_type == REQ_READ) ? in_rbin[PIXEL_BITS-1:0]
                                            : in_pixel[PIXEL_BITS-1:0];
    assign in_oob   = (in_rbin >> PIXEL_BITS) != '0;

    // Resolve stage
    logic                  r_s1_vld;
    logic                  r_s1_read;
    logic [PIXEL_BITS-1:0] r_s1_addr;
    logic                  r_s1_oob;

    // Running state
    logic [TOT_W-1:0]      r_pix_seen;
    logic [COUNT_W-1:0]    r_max;
    logic [PIXEL_BITS-1:0] r_mode;
    logic [EPOCH_W-1:0]    r_epoch;

    // Forwarding of the write made at the edge the current item was read
    logic                  r_fwd_vld;
    logic [PIXEL_BITS-1:0] r_fwd_addr;
    logic [COUNT_W-1:0]    r_fwd_cnt;

    // Memory sweep
    logic                  r_sw_rd;
    logic                  r_sw_wr;
    logic                  r_sw_zero;
    logic [PIXEL_BITS-1:0] r_sw_ra;
    logic [PIXEL_BITS-1:0] r_sw_wa;
    logic [COUNT_W-1:0]    sw_cnt;

    // Output queue
    t_result               r_fifo [FIFO_DEPTH];
    logic [1:0]            r_wp;
    logic [1:0]            r_rp;
    logic [1:0]            r_cnt;
    logic                  push;
    logic                  pop;
    t_result               res;

    // ------------------------------------------------------------------
    // Resolve logic
    // ------------------------------------------------------------------
    logic                  fwd_hit;
    logic [COUNT_W-1:0]    stored;
    logic                  frame_start;
    logic                  frame_end;
    logic                  is_pix;
    logic                  do_count;
    logic [COUNT_W-1:0]    base;
    logic [COUNT_W-1:0]    bump;
    logic [COUNT_W-1:0]    max_base;
    logic [COUNT_W-1:0]    n_max;
    logic [PIXEL_BITS-1:0] n_mode;
    logic [EPOCH_W-1:0]    n_epoch;
    logic                  sweep_trig;

    always_comb begin
        fwd_hit     = r_fwd_vld && (r_fwd_addr == r_s1_addr);
        stored      = fwd_hit ? r_fwd_cnt : ((rd_tag == r_epoch) ? rd_cnt : '0);
        frame_start = (r_pix_seen == '0);
        frame_end   = ({1'b0, r_pix_seen} + (TOT_W + 1)'(1)) >= {1'b0, r_total};
        is_pix      = r_s1_vld && (r_s1_read == REQ_PIXEL);
        do_count    = is_pix && r_count_en;
        base        = frame_start ? '0 : stored;
        bump        = (base == COUNT_MAX) ? base : base + COUNT_W'(1);
        max_base    = frame_start ? '0 : r_max;
        n_epoch     = frame_start ? r_epoch + EPOCH_W'(1) : r_epoch;
        if (do_count && (bump > max_base)) begin
            n_max  = bump;
            n_mode = r_s1_addr;
        end else begin
            n_max  = max_base;
            n_mode = r_mode;
        end
        // last frame of an epoch cycle: renumber the memory before the next frame
        sweep_trig = is_pix && frame_end && (n_epoch == EPOCH_MAX);

        push = r_s1_vld && ((r_s1_read == REQ_READ) || frame_end);
        res  = '0;
        if (r_s1_read == REQ_READ) begin
            res.kind      = KIND_READ;
            res.bin_count = r_s1_oob ? '0 : stored;
        end else begin
            res.kind       = KIND_SUMMARY;
            res.mode_count = n_max;
            res.mode_bin   = BIN_W'(n_mode);
        end
    end

    // Sweep keeps counts of the current epoch under tag zero, zeroes the rest (all of them after reset)
    assign sw_cnt = (!r_sw_zero && (rd_tag == r_epoch)) ? rd_cnt : '0;

    always_comb begin
        mem_raddr = r_sw_rd ? r_sw_ra : in_addr;
        mem_we    = r_sw_wr || do_count;
        if (r_sw_wr) begin
            mem_waddr = r_sw_wa;
            mem_wdata = {EPOCH_W'(0), sw_cnt};
        end else begin
            mem_waddr = r_s1_addr;
            mem_wdata = {n_epoch, bump};
        end
    end

    assign s_axis_tready = ((3'(r_cnt) + 3'(r_s1_vld)) < 3'(FIFO_DEPTH))
                           && !r_sw_rd && !r_sw_wr && !sweep_trig;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_pix_seen <= '0;
            r_max      <= '0;
            r_mode     <= '0;
            r_epoch    <= '0;
            r_fwd_vld  <= 1'b0;
            r_sw_rd    <= 1'b1;
            r_sw_wr    <= 1'b0;
            r_sw_zero  <= 1'b1;
            r_sw_ra    <= '0;
        end else begin
            r_s1_vld  <= in_acc;
            r_fwd_vld <= do_count;

            if (is_pix) begin
                r_pix_seen <= frame_end ? '0 : r_pix_seen + TOT_W'(1);
                r_max      <= n_max;
                r_mode     <= n_mode;
                r_epoch    <= n_epoch;
            end

            if (sweep_trig) begin
                r_sw_rd <= 1'b1;
                r_sw_ra <= '0;
            end else if (r_sw_rd) begin
                r_sw_ra <= r_sw_ra + PIXEL_BITS'(1);
                if (r_sw_ra == {PIXEL_BITS{1'b1}}) begin
                    r_sw_rd <= 1'b0;
                end
            end
            r_sw_wr <= r_sw_rd;

            // last sweep write: memory now all under tag zero
            if (r_sw_wr && !r_sw_rd) begin
                r_epoch   <= '0;
                r_sw_zero <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_read <= in_type;
            r_s1_addr <= in_addr;
            r_s1_oob  <= in_oob;
        end
        r_fwd_addr <= r_s1_addr;
        r_fwd_cnt  <= bump;
        r_sw_wa    <= r_sw_ra;
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    assign pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == 2'(FIFO_DEPTH - 1)) ? '0 : r_wp + 2'd1;
            end
            if (pop) begin
                r_rp <= (r_rp == 2'(FIFO_DEPTH - 1)) ? '0 : r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wp] <= res;
        end
    end

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tuser  = r_fifo[r_rp].kind;
    assign m_axis_tdata  = {(OUT_DATA_W - 2*COUNT_W - BIN_W)'(0),
                            r_fifo[r_rp].bin_count,
                            r_fifo[r_rp].mode_bin,
                            r_fifo[r_rp].mode_count};

endmodule

// ----- tb/pxhist_checker.sv -----
// Checker for the pixel histogram unit: mirrors registers, predicts and compares results.
`timescale 1ns / 1ps

module pxhist_checker
    import pxhist_pkg::*;
#(
    parameter int MAX_SIDE = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [3:0]            i_paddr,
    input  logic [31:0]           i_pwdata,
    input  logic                  i_pready,
    input  logic                  i_s_tvalid,
    input  logic                  i_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic [0:0]            i_s_tuser,
    input  logic                  i_m_tvalid,
    input  logic                  i_m_tready,
    input  logic [OUT_DATA_W-1:0] i_m_tdata,
    input  logic [0:0]            i_m_tuser,
    output int                    o_fail_count,
    output int                    o_pending
);

    logic [CFG_SIDE_W-1:0] cfg_width;
    logic [CFG_SIDE_W-1:0] cfg_height;
    logic                  cfg_count_en;

    logic [COUNT_W-1:0]    bin_hist [logic [BIN_W-1:0]];
    logic [23:0]           frame_pixels;
    logic [COUNT_W-1:0]    peak_count;
    logic [BIN_W-1:0]      peak_bin;

    t_result               predicted_results [$];
    int                    results_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        results_seen = 0;
    end

    function automatic int unsigned clamp_side(input logic [CFG_SIDE_W-1:0] v);
        if (v < 1)
            return 1;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return v;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: result %0d, %s: got 0x%0h, want 0x%0h", $time, results_seen, what,
                 got, want);
        o_fail_count++;
    endtask

    // bin update and running-mode tracking for one accepted request
    task automatic bin_request(input logic rq, input logic [BIN_W-1:0] px,
                               input logic [BIN_W-1:0] rb);
        t_result             res;
        logic [COUNT_W-1:0]  cnt;
        longint unsigned     frame_size;
        res = '0;
        if (rq == REQ_READ) begin
            res.kind      = KIND_READ;
            res.bin_count = bin_hist.exists(rb) ? bin_hist[rb] : '0;
            predicted_results.push_back(res);
        end else begin
            frame_size = clamp_side(cfg_width) * clamp_side(cfg_height);
            if (frame_pixels == 0) begin
                bin_hist.delete();
                peak_count = '0;
            end
            if (cfg_count_en) begin
                cnt = bin_hist.exists(px) ? bin_hist[px] : '0;
                if (cnt != COUNT_MAX)
                    cnt = cnt + 1'b1;
                bin_hist[px] = cnt;
                if (cnt > peak_count) begin
                    peak_count = cnt;
                    peak_bin   = px;
                end
            end
            if (longint'(frame_pixels) + 1 >= frame_size) begin
                frame_pixels   = '0;
                res.kind       = KIND_SUMMARY;
                res.mode_count = peak_count;
                res.mode_bin   = peak_bin;
                predicted_results.push_back(res);
            end else begin
                frame_pixels = frame_pixels + 1'b1;
            end
        end
    endtask

    task automatic compare_result(input logic [OUT_DATA_W-1:0] d, input logic k);
        t_result want;
        results_seen++;
        if (predicted_results.size() == 0) begin
            report_mismatch("result with nothing awaited", k, 0);
        end else begin
            want = predicted_results.pop_front();
            if (k !== want.kind)
                report_mismatch("result_kind", k, want.kind);
            if (d[24:0] !== want.mode_count)
                report_mismatch("mode_count", d[24:0], want.mode_count);
            if (d[40:25] !== want.mode_bin)
                report_mismatch("mode_bin", d[40:25], want.mode_bin);
            if (d[65:41] !== want.bin_count)
                report_mismatch("bin_count", d[65:41], want.bin_count);
            if (d[71:66] !== '0)
                report_mismatch("tdata padding", d[71:66], 0);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_width    = 13'd1024;
            cfg_height   = 13'd1024;
            cfg_count_en = 1'b1;
            bin_hist.delete();
            frame_pixels = '0;
            peak_count   = '0;
            peak_bin     = '0;
            predicted_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[3:2]))
                    REG_FRAME_WIDTH:  cfg_width    = i_pwdata[CFG_SIDE_W-1:0];
                    REG_FRAME_HEIGHT: cfg_height   = i_pwdata[CFG_SIDE_W-1:0];
                    REG_COUNT_EN:     cfg_count_en = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                bin_request(i_s_tuser[0], i_s_tdata[15:0], i_s_tdata[31:16]);
            if (i_m_tvalid && i_m_tready)
                compare_result(i_m_tdata, i_m_tuser[0]);
        end
        o_pending = predicted_results.size();
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the pixel histogram testbench: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module testbench
    import pxhist_pkg::*;
();

    // cycles with no transaction anywhere before the run is abandoned; the bin sweep
    // after reset and every 255th frame alone keeps the input closed while it walks all bins
    localparam int QUIET_LIMIT  = 300000;
    // long receiver hold-off, enough to fill the pipeline and output queue
    localparam int HOLD_CYCLES  = 300;
    // settle time after the last awaited result before a register write
    localparam int SETTLE       = 8;
    localparam int PHASE_ITEMS  = 310;
    // pixels sent into the oversized frame before it is shrunk
    localparam int BIG_PIXELS   = 96;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [3:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;

    int                    fail_count;
    int                    awaited;
    int                    quiet_cycles = 0;
    int                    sender_idle_pct = 0;
    int                    sink_stall_pct = 0;
    bit                    hold_req = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    pixel_histogram_with_mode_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    pxhist_checker u_hist_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (awaited)
    );

    // Watchdog: any transaction on any channel restarts the count.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result sink. A hold request keeps tready low for a fixed stretch counted here,
    // otherwise tready follows the current stall percentage.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // APB write: setup then access phase, then the bus is left idle. Bits above the field
    // carry junk, which the block must mask off.
    task automatic apb_write(input t_reg_idx idx, input logic [31:0] val);
        logic [31:0] junk;
        junk = $urandom;
        if (idx == REG_COUNT_EN)
            val = (junk & ~32'h1) | (val & 32'h1);
        else
            val = (junk & ~32'h1FFF) | (val & 32'h1FFF);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_frame(input logic [12:0] w, input logic [12:0] h, input logic en);
        apb_write(REG_FRAME_WIDTH, 32'(w));
        apb_write(REG_FRAME_HEIGHT, 32'(h));
        apb_write(REG_COUNT_EN, 32'(en));
    endtask

    // Called on a falling edge; returns on the falling edge after the transaction.
    // tvalid is left high so a following item goes out back to back.
    task automatic push_req(input logic rq, input logic [15:0] px, input logic [15:0] rb);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tuser  <= 1'($urandom_range(1));
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {rb, px};
        s_axis_tuser  <= rq;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Sender pause: drop tvalid, wait for every awaited result, then let the
    // pipeline finish any pixel that produced none.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (awaited != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic random_frame_setup();
        logic [12:0] w;
        logic [12:0] h;
        w = ($urandom_range(9) == 0) ? 13'd0 : 13'($urandom_range(4, 1));
        h = ($urandom_range(9) == 0) ? 13'd0 : 13'($urandom_range(2, 1));
        set_frame(w, h, $urandom_range(99) < 85);
    endtask

    // Random traffic: mostly pixels clustered round a base value so bins collide and
    // modes move, a share of bin reads aimed at the same cluster, some wild values.
    task automatic run_phase(input int idle_pct, input int stall_pct, input bit long_hold);
        logic [15:0] base;
        logic [15:0] px;
        logic [15:0] rb;
        wait_drained();
        sender_idle_pct = idle_pct;
        sink_stall_pct  = stall_pct;
        base = 16'($urandom);
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 60 == 0) begin
                wait_drained();
                random_frame_setup();
            end
            if (n % 25 == 0)
                base = 16'($urandom);
            if (long_hold && n == PHASE_ITEMS / 2)
                hold_req = 1'b1;
            px = ($urandom_range(99) < 70) ? base ^ 16'($urandom_range(3)) : 16'($urandom);
            rb = ($urandom_range(99) < 70) ? base ^ 16'($urandom_range(3)) : 16'($urandom);
            if ($urandom_range(99) < 78)
                push_req(REQ_PIXEL, px, 16'($urandom));
            else
                push_req(REQ_READ, 16'($urandom), rb);
        end
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // --- directed ---
        set_frame(13'd2, 13'd2, 1'b1);
        // reads straight after the clearing sweep
        push_req(REQ_READ, 16'hFFFF, 16'h0000);
        push_req(REQ_READ, 16'h0000, 16'hFFFF);
        // extreme pixel values; a tie on the count keeps the earlier mode bin
        push_req(REQ_PIXEL, 16'h0000, 16'hFFFF);
        push_req(REQ_PIXEL, 16'hFFFF, 16'h0000);
        push_req(REQ_PIXEL, 16'hFFFF, 16'h0000);
        push_req(REQ_PIXEL, 16'h0000, 16'hFFFF);
        // bins keep the finished histogram between frames
        push_req(REQ_READ, 16'h0000, 16'hFFFF);
        push_req(REQ_READ, 16'hFFFF, 16'h0000);
        push_req(REQ_READ, 16'h0000, 16'h0001);
        wait_drained();

        // counting off: summary has zero max and the old mode bin, bins still cleared
        set_frame(13'd1, 13'd3, 1'b0);
        push_req(REQ_PIXEL, 16'd100, 16'h0);
        push_req(REQ_PIXEL, 16'd100, 16'h0);
        push_req(REQ_PIXEL, 16'd100, 16'h0);
        push_req(REQ_READ, 16'h0, 16'hFFFF);
        push_req(REQ_READ, 16'h0, 16'd100);
        wait_drained();

        // zero sides clamp to one: single pixel frames
        set_frame(13'd0, 13'd0, 1'b1);
        push_req(REQ_PIXEL, 16'd12345, 16'h0);
        push_req(REQ_PIXEL, 16'h0000, 16'h0);
        wait_drained();

        // shrinking the frame mid-frame ends it at the next pixel
        set_frame(13'd4, 13'd1, 1'b1);
        push_req(REQ_PIXEL, 16'd7, 16'h0);
        push_req(REQ_PIXEL, 16'd8, 16'h0);
        wait_drained();
        apb_write(REG_FRAME_WIDTH, 32'd1);
        push_req(REQ_PIXEL, 16'd9, 16'h0);
        push_req(REQ_READ, 16'h0, 16'd8);
        wait_drained();

        // oversized sides clamp to the maximum: no summary while filling, then the
        // frame is shrunk to one pixel and closes at the next one
        set_frame(13'd8191, 13'd8191, 1'b1);
        for (int n = 0; n < BIG_PIXELS; n++) begin
            case ($urandom_range(3))
                0:       push_req(REQ_PIXEL, 16'hFFFF, 16'($urandom));
                1:       push_req(REQ_PIXEL, 16'h0000, 16'($urandom));
                default: push_req(REQ_PIXEL, 16'($urandom), 16'($urandom));
            endcase
        end
        wait_drained();
        apb_write(REG_FRAME_WIDTH, 32'd1);
        apb_write(REG_FRAME_HEIGHT, 32'd1);
        push_req(REQ_PIXEL, 16'd42, 16'h0);
        push_req(REQ_READ, 16'h0, 16'hFFFF);
        wait_drained();

        // --- random phases ---
        run_phase(0, 0, 1'b1);
        run_phase(80, 0, 1'b0);
        run_phase(0, 80, 1'b0);
        run_phase(15, 15, 1'b0);

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && awaited == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
